FILE: sv/record_sort_and_group_assert.svh
// record_sort_and_group_assert.svh: assertion macros for the record sort block
// no dependencies; included by the top level, which holds the assertions
`ifndef RECORD_SORT_AND_GROUP_ASSERT_SVH
`define RECORD_SORT_AND_GROUP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/srg_pkg.sv
// srg_pkg: types and constants shared by the record sort and group block
// no dependencies; used by srg_cell and record_sort_and_group
`timescale 1ns / 1ps

package srg_pkg;

   localparam int ROLL_W  = 11;
   localparam int KEY_W   = 7;
   localparam int REC_W   = ROLL_W + 2 * KEY_W;
   localparam int TDATA_W = 32;

   // order modes
   localparam logic [1:0] MODE_SORT = 2'd0;
   localparam logic [1:0] MODE_AGE  = 2'd1;
   localparam logic [1:0] MODE_MARK = 2'd2;

   // one record, roll in the lowest bits
   typedef struct packed {
      logic [KEY_W-1:0]  mark;
      logic [KEY_W-1:0]  age;
      logic [ROLL_W-1:0] roll;
   } srg_rec_type;

   // what a cell shows its neighbor and the controller
   typedef struct packed {
      srg_rec_type rec;
      logic        valid;
      logic        done;
      logic        grp;
   } srg_link_type;

   // per-cell control
   typedef struct packed {
      logic load;
      logic rot;
      logic set_done;
      logic take_grp;
      logic clear;
   } srg_cell_ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SORT_SCAN,
      ST_SORT_EMIT,
      ST_GRP_LEAD,
      ST_GRP_SCAN,
      ST_FLUSH
   } srg_state_type;

endpackage

FILE: sv/srg_cell.sv
// srg_cell: one slot of the record ring, holds a record and its status bits
// depends on srg_pkg
`timescale 1ns / 1ps

module srg_cell import srg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  srg_cell_ctl_type    ctl,
   input  logic                key_sel,
   input  logic [KEY_W-1:0]    bcast_key,
   input  srg_rec_type         load_rec,
   input  srg_link_type        nb_in,
   output srg_link_type        link_out,
   output srg_link_type        view,
   output logic                match
);

   srg_rec_type rec_ff, rec_in;
   logic        valid_ff, valid_in;
   logic        done_ff, done_in;
   logic        grp_ff, grp_in;
   logic        done_pass, grp_pass;
   logic [KEY_W-1:0] key;

   // status as handed on, with this cycle's emission applied
   always_comb begin
      done_pass = done_ff | ctl.set_done;
      grp_pass  = grp_ff & ~ctl.set_done;
      key       = key_sel ? rec_ff.age : rec_ff.mark;
      match     = valid_ff & ~done_ff & (key == bcast_key);
   end

   // next state of the slot
   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      done_in  = done_pass;
      grp_in   = grp_pass;
      priority if (ctl.clear) begin
         valid_in = 1'b0;
         done_in  = 1'b0;
         grp_in   = 1'b0;
      end else if (ctl.rot) begin
         rec_in   = nb_in.rec;
         valid_in = nb_in.valid;
         done_in  = nb_in.done;
         grp_in   = nb_in.grp;
      end else begin
         if (ctl.load) begin
            rec_in   = load_rec;
            valid_in = 1'b1;
         end
         if (ctl.take_grp) begin
            grp_in = match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
         grp_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
         grp_ff   <= grp_in;
      end
      rec_ff <= rec_in;
   end

   always_comb begin
      link_out.rec   = rec_ff;
      link_out.valid = valid_ff;
      link_out.done  = done_pass;
      link_out.grp   = grp_pass;
      view.rec       = rec_ff;
      view.valid     = valid_ff;
      view.done      = done_ff;
      view.grp       = grp_ff;
   end

endmodule

FILE: sv/record_sort_and_group.sv
// record_sort_and_group: top level, ring of record cells and its controller
// depends on srg_pkg, srg_cell and record_sort_and_group_assert.svh
`timescale 1ns / 1ps
`include "record_sort_and_group_assert.svh"

// Records arrive one beat per cycle on req_ while the block is loading and
// are written into a ring of MAX_RECORDS cells; the beat with tlast ends the
// set and starts emission in the mode held in the csr register at that moment.
// The ring rotates one cell per cycle past a head cell while scanning, unless
// stalled; sort compares are made at the head, and in group modes every cell
// compares its key with the head's. In sort mode each emitted record is found
// by one full revolution, and one more such pass finds nothing left. In group
// modes every cell of the ring is offered once as leader, and each group found
// is marked and then emitted during one revolution. A final flush step moves
// the last beat to the output register. Back-pressure on rsp_ stalls the
// emitting steps; no new record is taken until the last beat of the run has
// been handed to the output register.
module record_sort_and_group import srg_pkg::*; #(
   parameter int MAX_RECORDS = 32
) (
   input  logic               clock,
   input  logic               reset,
   // records: [10:0] roll_number, [17:11] student_age, [24:18] student_mark
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   // results: [10:0] out_roll, [17:11] out_age, [24:18] out_mark
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tlast,
   // [0] none_found, [1] capacity_exceeded
   output logic [1:0]         rsp_tuser,
   // order mode register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_wdata
);

   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int IW = $clog2(MAX_RECORDS);

   srg_state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [1:0]    mode_csr_ff, mode_csr_in;
   logic [1:0]    mode_run_ff, mode_run_in;
   logic [IW-1:0] step_ff, step_in;
   logic [IW-1:0] lead_ff, lead_in;
   logic          cand_v_ff, cand_v_in;
   srg_rec_type   cand_rec_ff, cand_rec_in;
   logic [IW-1:0] cand_pos_ff, cand_pos_in;
   logic          hold_v_ff, hold_v_in;
   srg_rec_type   hold_rec_ff, hold_rec_in;
   logic          rsp_v_ff, rsp_v_in;
   srg_rec_type   rsp_rec_ff, rsp_rec_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_none_ff, rsp_none_in;
   logic          rsp_cap_ff, rsp_cap_in;

   srg_link_type     link [MAX_RECORDS];
   srg_link_type     view [MAX_RECORDS];
   srg_cell_ctl_type ctl  [MAX_RECORDS];
   logic [MAX_RECORDS-1:0] match;

   srg_rec_type      load_rec;
   logic             key_sel;
   logic [KEY_W-1:0] bcast_key;
   logic             req_fire, room, load_fire;
   logic             adv, head_qual, shared, last_step, sort_wins;

   // controller outputs
   logic        rot, take_grp, clear_all, set_done_head, set_done_sort;
   logic        emit_v;
   srg_rec_type emit_rec;

   assign csr_ready = 1'b1;
   assign load_rec  = srg_rec_type'(req_tdata[REC_W-1:0]);
   assign req_fire  = req_tvalid && req_tready;
   assign room      = (cnt_ff < CW'(MAX_RECORDS));
   assign load_fire = req_fire && room;
   assign adv       = !rsp_v_ff || rsp_tready;
   assign key_sel   = (mode_run_ff == MODE_AGE);
   assign bcast_key = key_sel ? view[0].rec.age : view[0].rec.mark;
   assign head_qual = view[0].valid && !view[0].done;
   assign shared    = |match[MAX_RECORDS-1:1];
   assign last_step = (step_ff == IW'(MAX_RECORDS - 1));
   assign sort_wins = head_qual && (!cand_v_ff || (view[0].rec.roll < cand_rec_ff.roll));

   // ring of cells, each fed by its upper neighbor
   for (genvar j = 0; j < MAX_RECORDS; j++) begin : g_cell
      always_comb begin
         ctl[j].load     = load_fire && (cnt_ff == CW'(j));
         ctl[j].rot      = rot;
         ctl[j].set_done = (set_done_head && (j == 0)) ||
                           (set_done_sort && (cand_pos_ff == IW'(j)));
         ctl[j].take_grp = take_grp;
         ctl[j].clear    = clear_all;
      end

      srg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[j]),
         .key_sel   (key_sel),
         .bcast_key (bcast_key),
         .load_rec  (load_rec),
         .nb_in     (link[(j + 1) % MAX_RECORDS]),
         .link_out  (link[j]),
         .view      (view[j]),
         .match     (match[j])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_tlast) begin
               if (mode_csr_ff == MODE_AGE || mode_csr_ff == MODE_MARK) begin
                  state_in = ST_GRP_LEAD;
               end else begin
                  state_in = ST_SORT_SCAN;
               end
            end
         end
         ST_SORT_SCAN: begin
            if (last_step) state_in = ST_SORT_EMIT;
         end
         ST_SORT_EMIT: begin
            if (adv) state_in = cand_v_ff ? ST_SORT_SCAN : ST_FLUSH;
         end
         ST_GRP_LEAD: begin
            if (head_qual && shared) begin
               state_in = ST_GRP_SCAN;
            end else if (lead_ff == IW'(MAX_RECORDS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_GRP_SCAN: begin
            if (adv && last_step) state_in = ST_GRP_LEAD;
         end
         ST_FLUSH: begin
            if (adv) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready    = 1'b0;
      rot           = 1'b0;
      take_grp      = 1'b0;
      clear_all     = 1'b0;
      set_done_head = 1'b0;
      set_done_sort = 1'b0;
      emit_v        = 1'b0;
      emit_rec      = view[0].rec;
      unique case (state_ff)
         ST_LOAD: req_tready = 1'b1;
         ST_SORT_SCAN: rot = 1'b1;
         ST_SORT_EMIT: begin
            emit_rec = cand_rec_ff;
            if (adv && cand_v_ff) begin
               emit_v        = 1'b1;
               set_done_sort = 1'b1;
            end
         end
         ST_GRP_LEAD: begin
            if (head_qual && shared) begin
               take_grp = 1'b1;
            end else begin
               rot = 1'b1;
            end
         end
         ST_GRP_SCAN: begin
            if (adv) begin
               rot = 1'b1;
               if (view[0].grp) begin
                  emit_v        = 1'b1;
                  set_done_head = 1'b1;
               end
            end
         end
         ST_FLUSH: clear_all = adv;
         default: req_tready = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      mode_csr_in = mode_csr_ff;
      mode_run_in = mode_run_ff;
      step_in     = step_ff;
      lead_in     = lead_ff;
      cand_v_in   = cand_v_ff;
      cand_rec_in = cand_rec_ff;
      cand_pos_in = cand_pos_ff;
      hold_v_in   = hold_v_ff;
      hold_rec_in = hold_rec_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_rec_in  = rsp_rec_ff;
      rsp_last_in = rsp_last_ff;
      rsp_none_in = rsp_none_ff;
      rsp_cap_in  = rsp_cap_ff;

      if (csr_valid) mode_csr_in = csr_wdata;

      // record load
      if (req_fire) begin
         if (room) begin
            cnt_in = cnt_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_tlast) begin
            mode_run_in = mode_csr_ff;
            step_in     = '0;
            lead_in     = '0;
            cand_v_in   = 1'b0;
         end
      end

      // sort scan keeps the earliest smallest roll
      if (state_ff == ST_SORT_SCAN) begin
         if (sort_wins) begin
            cand_v_in   = 1'b1;
            cand_rec_in = view[0].rec;
            cand_pos_in = step_ff;
         end
         step_in = last_step ? '0 : step_ff + IW'(1);
      end
      if (set_done_sort) cand_v_in = 1'b0;

      // group leader walk
      if (state_ff == ST_GRP_LEAD) begin
         if (head_qual && shared) begin
            step_in = '0;
         end else begin
            lead_in = lead_ff + IW'(1);
         end
      end
      if (state_ff == ST_GRP_SCAN && adv) begin
         step_in = last_step ? '0 : step_ff + IW'(1);
      end

      // one-deep hold so the final beat can carry tlast
      if (emit_v) begin
         if (hold_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_rec_in  = hold_rec_ff;
            rsp_last_in = 1'b0;
            rsp_none_in = 1'b0;
            rsp_cap_in  = ovf_ff;
         end
         hold_v_in   = 1'b1;
         hold_rec_in = emit_rec;
      end

      // last beat of the run
      if (clear_all) begin
         rsp_v_in    = 1'b1;
         rsp_rec_in  = hold_v_ff ? hold_rec_ff : '0;
         rsp_last_in = 1'b1;
         rsp_none_in = !hold_v_ff;
         rsp_cap_in  = ovf_ff;
         hold_v_in   = 1'b0;
         cnt_in      = '0;
         ovf_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         mode_csr_ff <= MODE_SORT;
         mode_run_ff <= MODE_SORT;
         step_ff     <= '0;
         lead_ff     <= '0;
         cand_v_ff   <= 1'b0;
         hold_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
         mode_csr_ff <= mode_csr_in;
         mode_run_ff <= mode_run_in;
         step_ff     <= step_in;
         lead_ff     <= lead_in;
         cand_v_ff   <= cand_v_in;
         hold_v_ff   <= hold_v_in;
         rsp_v_ff    <= rsp_v_in;
      end
      cand_rec_ff <= cand_rec_in;
      cand_pos_ff <= cand_pos_in;
      hold_rec_ff <= hold_rec_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
      rsp_cap_ff  <= rsp_cap_in;
   end

   // result beat
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{(TDATA_W - REC_W){1'b0}}, rsp_rec_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_cap_ff, rsp_none_ff};

   // checks
   `SRG_ASSERT_NOW(a_none_is_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast && (rsp_tdata == '0), "none_found beat must be last and empty")
   `SRG_ASSERT_NOW(a_load_no_hold, clock, reset, state_ff == ST_LOAD, !hold_v_ff, "held result left over while loading")
   `SRG_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(MAX_RECORDS), "record count beyond capacity")
   `SRG_ASSERT_NOW(a_leader_marked, clock, reset, state_ff == ST_GRP_SCAN && step_ff == '0, view[0].grp, "group scan must start at its leader")
   `SRG_ASSERT_NEXT(a_flush_clears, clock, reset, state_ff == ST_FLUSH && adv, state_ff == ST_LOAD && cnt_ff == '0, "flush must empty the store")

endmodule
